// ===== rtl/rau_pkg.sv =====
// rau_pkg: constants and operation codes for the rational arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int RES_NUM_W = 33;
	localparam int RES_DEN_W = 31;
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
endpackage
`default_nettype wire

// ===== rtl/rau_if.sv =====
// rau_in_if / rau_out_if: valid/ready channels for operands and results.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rau_in_if import rau_pkg::*; #(parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF) ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic signed [OPERAND_WIDTH-1:0] a_num;
	logic signed [OPERAND_WIDTH-1:0] a_den;
	logic signed [OPERAND_WIDTH-1:0] b_num;
	logic signed [OPERAND_WIDTH-1:0] b_den;
	modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0] res_den;
	logic zero_den_error;
	modport source (output valid, res_num, res_den, zero_den_error, input ready);
	modport sink (input valid, res_num, res_den, zero_den_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/rational_arith_unit.sv =====
// rational_arith_unit: fraction add/sub/mul/div/reduce with gcd reduction.
// Depends on rau_pkg and rau_if.
// Sequence: setup states MUL1 and MUL2 (plus SUM for add/sub), then binary gcd steps,
// then restoring division of numerator, then denominator (MW = 2*width+1 bits each).
// One item at a time: input ready only when idle, after the result transfer.
// One shared subtract/compare unit does both divisions. Reset clears control state only.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit import rau_pkg::*; #(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rau_in_if.sink in_ch,
	rau_out_if.source out_ch
);
	localparam int W = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int MW = PW + 1;
	localparam int CW = $clog2(MW + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_SUM = 3'd3;
	localparam logic [2:0] ST_GCD = 3'd4;
	localparam logic [2:0] ST_DIVN = 3'd5;
	localparam logic [2:0] ST_DIVD = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	logic [2:0] state_q;
	logic [KIND_W-1:0] kind_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic sn_an_q, sn_ad_q, sn_bn_q, sn_bd_q;
	logic [MW-1:0] nm_q, dm_q, p1_q;
	logic neg_q, p1n_q;
	logic [MW-1:0] gx_q, gy_q;
	logic [CW-1:0] sh_q, cnt_q;
	logic [MW-1:0] quo_q, rem_q, dvd_q;
	logic [MW-1:0] qn_q;
	logic signed [RES_NUM_W-1:0] rnum_q;
	logic [RES_DEN_W-1:0] rden_q;
	logic err_q;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		mag_of = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// shared multiplier operands
	logic [W-1:0] mx, my;
	logic [PW-1:0] prod;
	always_comb begin
		mx = an_q;
		my = bd_q;
		case (state_q)
			ST_MUL1: begin
				if (kind_q == KIND_MUL) begin
					mx = an_q; my = bn_q;
				end else begin
					mx = an_q; my = bd_q;
				end
			end
			ST_MUL2: begin
				if (kind_q == KIND_ADD || kind_q == KIND_SUB) begin
					mx = bn_q; my = ad_q;
				end else if (kind_q == KIND_DIV) begin
					mx = ad_q; my = bn_q;
				end else begin
					mx = ad_q; my = bd_q;
				end
			end
			ST_SUM: begin
				mx = ad_q; my = bd_q;
			end
			default: begin
				mx = an_q; my = bd_q;
			end
		endcase
	end
	assign prod = PW'(mx) * PW'(my);

	// shared subtractor
	logic [MW-1:0] sa, sb, sdiff;
	logic sbor;
	logic [MW-1:0] rsh;
	always_comb begin
		rsh = {rem_q[MW-2:0], dvd_q[MW-1]};
		sa = gx_q;
		sb = gy_q;
		if (state_q == ST_DIVN || state_q == ST_DIVD) begin
			sa = rsh;
			sb = gx_q;
		end else if (state_q == ST_SUM) begin
			sa = p1_q;
			sb = nm_q;
		end
		{sbor, sdiff} = {1'b0, sa} - {1'b0, sb};
	end

	logic is_as;
	assign is_as = (kind_q == KIND_ADD) || (kind_q == KIND_SUB);
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.res_num = rnum_q;
	assign out_ch.res_den = rden_q;
	assign out_ch.zero_den_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_ch.valid) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= is_as ? ST_SUM : ST_GCD;
				ST_SUM: state_q <= ST_GCD;
				ST_GCD: begin
					if (dm_q == '0) state_q <= ST_OUT;
					else if (gx_q == '0 || gy_q == '0 || gx_q == gy_q)
						state_q <= ST_DIVN;
				end
				ST_DIVN: if (cnt_q == CW'(MW - 1)) state_q <= ST_DIVD;
				ST_DIVD: if (cnt_q == CW'(MW - 1)) state_q <= ST_OUT;
				ST_OUT: if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= in_ch.kind;
				an_q <= mag_of(in_ch.a_num);
				ad_q <= mag_of(in_ch.a_den);
				bn_q <= mag_of(in_ch.b_num);
				bd_q <= mag_of(in_ch.b_den);
				sn_an_q <= in_ch.a_num[W-1];
				sn_ad_q <= in_ch.a_den[W-1];
				sn_bn_q <= in_ch.b_num[W-1];
				sn_bd_q <= in_ch.b_den[W-1];
			end
			ST_MUL1: begin
				if (kind_q == KIND_ADD || kind_q == KIND_SUB || kind_q == KIND_MUL
						|| kind_q == KIND_DIV) begin
					p1_q <= MW'(prod);
					p1n_q <= sn_an_q ^ (kind_q == KIND_MUL ? sn_bn_q : sn_bd_q);
				end else begin
					p1_q <= MW'(an_q);
					p1n_q <= sn_an_q;
				end
			end
			ST_MUL2: begin
				if (is_as) begin
					nm_q <= MW'(prod);
					neg_q <= sn_bn_q ^ sn_ad_q ^ (kind_q == KIND_SUB);
				end else begin
					nm_q <= p1_q;
					if (kind_q == KIND_MUL || kind_q == KIND_DIV) begin
						dm_q <= MW'(prod);
						neg_q <= p1n_q ^ sn_ad_q ^ (kind_q == KIND_DIV ? sn_bn_q : sn_bd_q);
					end else begin
						dm_q <= MW'(ad_q);
						neg_q <= p1n_q ^ sn_ad_q;
					end
					gx_q <= p1_q;
					gy_q <= (kind_q == KIND_MUL || kind_q == KIND_DIV) ? MW'(prod)
						: MW'(ad_q);
					sh_q <= '0;
				end
			end
			ST_SUM: begin
				// p1 sign p1n_q, second term sign neg_q (relative to den sign later)
				if (p1n_q == neg_q) begin
					nm_q <= p1_q + nm_q;
					gx_q <= p1_q + nm_q;
				end else if (!sbor) begin
					nm_q <= sdiff;
					gx_q <= sdiff;
				end else begin
					nm_q <= nm_q - p1_q;
					gx_q <= nm_q - p1_q;
					p1n_q <= neg_q;
				end
				neg_q <= ((p1n_q == neg_q) || !sbor) ? p1n_q ^ sn_ad_q ^ sn_bd_q
					: neg_q ^ sn_ad_q ^ sn_bd_q;
				dm_q <= MW'(prod);
				gy_q <= MW'(prod);
				sh_q <= '0;
			end
			ST_GCD: begin
				cnt_q <= '0;
				if (dm_q == '0) begin
					rnum_q <= '0;
					rden_q <= '0;
					err_q <= 1'b1;
				end else if (gx_q == '0 || gy_q == '0 || gx_q == gy_q) begin
					gx_q <= (gx_q == '0 ? gy_q : gx_q) << sh_q;
					dvd_q <= nm_q;
					rem_q <= '0;
					err_q <= 1'b0;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					sh_q <= sh_q + 1'b1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (!sbor) begin
					gx_q <= sdiff >> 1;
				end else begin
					gy_q <= (gy_q - gx_q) >> 1;
				end
			end
			ST_DIVN, ST_DIVD: begin
				quo_q <= {quo_q[MW-2:0], ~sbor};
				if (cnt_q == CW'(MW - 1)) begin
					cnt_q <= '0;
					if (state_q == ST_DIVN) begin
						qn_q <= {quo_q[MW-2:0], ~sbor};
						dvd_q <= dm_q;
						rem_q <= '0;
					end else begin
						rnum_q <= (neg_q && qn_q != '0)
							? RES_NUM_W'(-qn_q) : RES_NUM_W'(qn_q);
						rden_q <= RES_DEN_W'({quo_q[MW-2:0], ~sbor});
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					dvd_q <= dvd_q << 1;
					rem_q <= sbor ? rsh : sdiff;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
